>>> rtl/lplt_pkg.sv
// Shared types and constants for the lane path trim block.
`default_nettype none
package lplt_pkg;
  localparam int unsigned MaxLanes = 64;
  localparam int unsigned IdxW = $clog2(MaxLanes);
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [16:0] OneQ16 = 17'h10000;
  localparam int unsigned EntryW = 25;

  localparam logic [1:0] StatTrim = 2'd0;
  localparam logic [1:0] StatUnpruned = 2'd1;
  localparam logic [1:0] StatAbsent = 2'd2;

  localparam logic [1:0] RegFront = 2'd0;
  localparam logic [1:0] RegBack = 2'd1;
  localparam logic [1:0] RegMin = 2'd2;

  typedef struct packed {
    logic [31:0] lane_id;
    logic [23:0] lane_len;
    logic        lane_known;
    logic [31:0] point_lane_id;
    logic [16:0] point_fraction;
    logic        last;
  } lane_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  start_index;
    logic [16:0] start_frac;
    logic [5:0]  end_index;
    logic [16:0] end_frac;
  } trim_result_t;
endpackage
`default_nettype wire

>>> rtl/lplt_if.sv
// Valid/ready channel interface carrying one payload.
`default_nettype none
interface lplt_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/lplt_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module lplt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/lane_path_length_trim.sv
// Sequence: lanes are stored while loading; after the last lane the walk reads back from the
// anchor lane and then forward, one read per visited lane, with a bit-serial division at each
// end where a cut is found, and the result is then registered.
// Throughput: one lane per cycle while loading; input holds off during the walk and while a
// finished walk waits for the result register to drain.
// Reset: registers take their reset values, path state clears, no lane store clearing.
`default_nettype none
module lane_path_length_trim (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  lplt_if.sink             in_if,
  lplt_if.source           out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int unsigned IW = lplt_pkg::IdxW;
  localparam int unsigned CW = lplt_pkg::CntW;

  localparam logic [2:0] SLoad = 3'd0;
  localparam logic [2:0] SBack = 3'd1;
  localparam logic [2:0] SBDiv = 3'd2;
  localparam logic [2:0] SFwd  = 3'd3;
  localparam logic [2:0] SFDiv = 3'd4;
  localparam logic [2:0] SDone = 3'd5;

  logic [23:0] front_q, back_q;
  logic [9:0]  minlen_q;
  logic [1:0]  reg_sel;
  assign reg_sel = paddr[3:2];
  assign pready = 1'b1;

  always_comb begin
    unique case (reg_sel)
      lplt_pkg::RegFront: prdata = {8'd0, front_q};
      lplt_pkg::RegBack:  prdata = {8'd0, back_q};
      lplt_pkg::RegMin:   prdata = {22'd0, minlen_q};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0; back_q <= '0; minlen_q <= 10'd1;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        lplt_pkg::RegFront: front_q <= pwdata[23:0];
        lplt_pkg::RegBack:  back_q <= pwdata[23:0];
        lplt_pkg::RegMin:   minlen_q <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  logic [2:0]    st_q;
  logic [CW-1:0] cnt_q;
  logic          anc_v_q;
  logic [IW-1:0] anc_q;
  logic [16:0]   afrac_q;
  logic [31:0]   aid_q;
  logic [IW-1:0] idx_q;       // lane under walk
  logic          rd_v_q;      // read data for idx_q valid this cycle
  logic [41:0]   cut_q;
  logic          failed_q;
  logic          absent_q;
  logic [IW-1:0] sidx_q, eidx_q;
  logic [16:0]   sfrac_q, efrac_q;
  // bit-serial divider
  logic [41:0]   num_q;
  logic [24:0]   rem_q;
  logic [23:0]   den_q;
  logic [5:0]    dcnt_q;
  logic          out_v_q;
  lplt_pkg::trim_result_t out_q;

  lplt_pkg::lane_item_t it;
  assign it = in_if.data;

  logic          acc;
  assign in_if.ready = (st_q == SLoad);
  assign acc = in_if.valid && in_if.ready;

  logic [31:0]   cur_aid;
  logic [16:0]   cur_afrac;
  logic          first;
  assign first = (cnt_q == '0);
  assign cur_aid = first ? it.point_lane_id : aid_q;
  assign cur_afrac = first ? ((it.point_fraction > lplt_pkg::OneQ16) ? lplt_pkg::OneQ16
                                                                      : it.point_fraction)
                           : afrac_q;
  logic room;
  assign room = (cnt_q < CW'(lplt_pkg::MaxLanes));

  logic          we;
  logic [IW-1:0] raddr;
  logic [24:0]   rdata;
  assign we = acc && room;
  lplt_ram #(.Width(lplt_pkg::EntryW), .Depth(lplt_pkg::MaxLanes)) u_ram (
    .clk_i, .we_i(we), .waddr_i(cnt_q[IW-1:0]),
    .wdata_i({it.lane_known, it.lane_len}), .raddr_i(raddr), .rdata_o(rdata)
  );

  // walk decode of the entry just read
  logic [23:0] ln;
  logic        known, skip, at_a;
  logic [41:0] seg, ahead;
  logic [16:0] afrac_rest;
  assign ln = rdata[23:0];
  assign known = rdata[24];
  assign skip = (ln < {14'd0, minlen_q});
  assign at_a = (idx_q == anc_q);
  assign afrac_rest = lplt_pkg::OneQ16 - afrac_q;
  assign seg = at_a ? ({25'd0, afrac_q} * {18'd0, ln}) : {2'd0, ln, 16'd0};
  assign ahead = at_a ? ({25'd0, afrac_rest} * {18'd0, ln}) : {2'd0, ln, 16'd0};
  logic [IW-1:0] lastidx;
  assign lastidx = IW'(cnt_q - 1'b1);
  logic [IW-1:0] nidx;
  always_comb begin
    nidx = idx_q;
    if (st_q == SBack && rd_v_q) nidx = idx_q - 1'b1;
    else if (st_q == SFwd && rd_v_q) nidx = idx_q + 1'b1;
    else if (st_q == SBDiv && dcnt_q == 6'd0) nidx = anc_q;
  end
  assign raddr = nidx;

  logic [25:0] trial;
  assign trial = {rem_q, num_q[41]} - {2'd0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SLoad; cnt_q <= '0; anc_v_q <= 1'b0; out_v_q <= 1'b0; rd_v_q <= 1'b0;
      anc_q <= '0; afrac_q <= '0; aid_q <= '0; idx_q <= '0; cut_q <= '0;
      failed_q <= 1'b0; absent_q <= 1'b0;
      sidx_q <= '0; eidx_q <= '0; sfrac_q <= '0; efrac_q <= '0;
      num_q <= '0; rem_q <= '0; den_q <= '0; dcnt_q <= '0; out_q <= '0;
    end else begin
      if (out_if.valid && out_if.ready) out_v_q <= 1'b0;
      unique case (st_q)
        SLoad: if (acc) begin
          if (room) begin
            cnt_q <= cnt_q + 1'b1;
            if (!anc_v_q && it.lane_id == cur_aid) begin
              anc_v_q <= 1'b1; anc_q <= cnt_q[IW-1:0];
            end
          end
          if (first) begin aid_q <= cur_aid; afrac_q <= cur_afrac; end
          if (it.last) begin
            if (!(anc_v_q || (room && it.lane_id == cur_aid))) begin
              absent_q <= 1'b1;
              st_q <= SDone;
            end else begin
              absent_q <= 1'b0;
              st_q <= SBack; rd_v_q <= 1'b0;
              idx_q <= anc_v_q ? anc_q : cnt_q[IW-1:0];
              cut_q <= {2'd0, back_q, 16'd0};
              failed_q <= 1'b0;
              sidx_q <= '0; sfrac_q <= '0;
              eidx_q <= room ? cnt_q[IW-1:0] : lastidx; efrac_q <= lplt_pkg::OneQ16;
            end
          end
        end
        SBack: begin
          if (!rd_v_q) rd_v_q <= 1'b1;
          else if (!known) begin
            failed_q <= 1'b1; st_q <= SDone;
          end else if (!skip && seg >= cut_q) begin
            sidx_q <= idx_q; num_q <= seg - cut_q; den_q <= ln; rem_q <= '0;
            dcnt_q <= 6'd42; st_q <= SBDiv;
          end else if (idx_q == '0) begin
            // ran off the front of the path
            idx_q <= anc_q; rd_v_q <= 1'b0; st_q <= SFwd;
            cut_q <= {2'd0, front_q, 16'd0};
          end else begin
            idx_q <= nidx;
            if (!skip) cut_q <= cut_q - seg;
          end
        end
        SBDiv, SFDiv: begin
          if (dcnt_q != 6'd0) begin
            rem_q <= trial[25] ? {rem_q[23:0], num_q[41]} : trial[24:0];
            num_q <= {num_q[40:0], ~trial[25]};
            dcnt_q <= dcnt_q - 1'b1;
          end else begin
            if (st_q == SBDiv) begin
              sfrac_q <= (den_q == '0 || num_q > 42'(lplt_pkg::OneQ16)) ? lplt_pkg::OneQ16
                                                                        : num_q[16:0];
              st_q <= SFwd; idx_q <= anc_q; rd_v_q <= 1'b0;
              cut_q <= {2'd0, front_q, 16'd0};
            end else begin
              efrac_q <= (den_q == '0 || num_q > 42'(lplt_pkg::OneQ16)) ? lplt_pkg::OneQ16
                                                                        : num_q[16:0];
              st_q <= SDone;
            end
          end
        end
        SFwd: begin
          if (!rd_v_q) rd_v_q <= 1'b1;
          else if (!known) begin
            failed_q <= 1'b1; st_q <= SDone;
          end else if (!skip && ahead >= cut_q) begin
            eidx_q <= idx_q; den_q <= ln; rem_q <= '0; dcnt_q <= 6'd42;
            num_q <= at_a ? seg + cut_q : cut_q;
            st_q <= SFDiv;
          end else if (idx_q == lastidx) begin
            st_q <= SDone;
          end else begin
            idx_q <= nidx;
            if (!skip) cut_q <= cut_q - ahead;
          end
        end
        SDone: if (!out_v_q) begin
          out_q.status <= absent_q ? lplt_pkg::StatAbsent
                        : failed_q ? lplt_pkg::StatUnpruned : lplt_pkg::StatTrim;
          out_q.start_index <= (absent_q || failed_q) ? 6'd0 : 6'(sidx_q);
          out_q.start_frac <= (absent_q || failed_q) ? 17'd0 : sfrac_q;
          out_q.end_index <= absent_q ? 6'd0 : failed_q ? 6'(lastidx) : 6'(eidx_q);
          out_q.end_frac <= absent_q ? 17'd0 : failed_q ? lplt_pkg::OneQ16 : efrac_q;
          out_v_q <= 1'b1;
          cnt_q <= '0; anc_v_q <= 1'b0; st_q <= SLoad;
        end
        default: st_q <= SLoad;
      endcase
    end
  end

  assign out_if.valid = out_v_q;
  assign out_if.data = out_q;

`ifndef NO_ASSERTIONS
  a_no_acc_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != SLoad) |-> !acc) else $error("lane taken during walk");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(lplt_pkg::MaxLanes)) else $error("lane count overflow");
  a_anc_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    anc_v_q |-> (CW'(anc_q) < cnt_q)) else $error("anchor beyond path");
  a_done_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == SDone && !out_v_q) |=> (out_v_q && cnt_q == '0))
    else $error("result not issued");
`endif
endmodule
`default_nettype wire
